// File: src/tvbb_pkg.sv
package tvbb_pkg;

    // Field widths
    localparam int unsigned VERT_W  = 16;
    localparam int unsigned COEF_W  = 16;
    localparam int unsigned OFS_W   = 21;
    localparam int unsigned PAD_W   = 16;
    localparam int unsigned COORD_W = 24;
    localparam int unsigned CFG_W   = 64;
    localparam int unsigned IDX_W   = 3;

    // Signed and unsigned 24-bit limits
    localparam logic signed [COORD_W-1:0] S24_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] S24_MIN = -24'sh800000;
    localparam logic [COORD_W-1:0]        U24_MAX = 24'hFFFFFF;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_ROW_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_TRANS = 3'd3;
    localparam logic [IDX_W-1:0] REG_PAD   = 3'd4;

    // Register reset values
    localparam logic [47:0] ROW_X_RST = 48'h0000_0000_1000;
    localparam logic [47:0] ROW_Y_RST = 48'h0000_1000_0000;
    localparam logic [47:0] ROW_Z_RST = 48'h1000_0000_0000;

    typedef struct packed {
        logic signed [VERT_W-1:0] vertex_x;
        logic signed [VERT_W-1:0] vertex_y;
        logic signed [VERT_W-1:0] vertex_z;
        logic                     last_vertex;
    } t_vertex;

    typedef struct packed {
        logic signed [COORD_W-1:0] box_min_x;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_min_z;
        logic [COORD_W-1:0]        box_size_x;
        logic [COORD_W-1:0]        box_size_y;
        logic [COORD_W-1:0]        box_size_z;
        logic                      saturated;
    } t_box;

endpackage

// File: src/transformed_vertex_bounding_box.sv
// Channel   Dir  Handshake                 Word
// vertex    in   i_valid / o_stall         i_data  (t_vertex)
// box       out  o_valid / i_stall         o_data  (t_box)
// config    in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One vertex is taken every cycle unless the output stalls; the box for a last vertex
// passes input reg, product reg, world coordinate reg, extreme snapshot, output reg.
// The rate is set by the single pass through the nine parallel 16x16 multipliers.
// Synchronous active-low reset: valids clear, extremes re-arm, registers reset; no sweep.
// A stalled output word freezes the whole pipeline; o_stall follows at once.
module transformed_vertex_bounding_box (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  tvbb_pkg::t_vertex            i_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output tvbb_pkg::t_box               o_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tvbb_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [tvbb_pkg::CFG_W-1:0]   i_cfg_data
);
    import tvbb_pkg::*;

    // configuration registers
    logic [47:0] r_row [3];
    logic [62:0] r_trans;
    logic [47:0] r_pad;

    // pipeline
    logic                       advance;
    logic                       r_in_valid;
    t_vertex                    r_in;
    logic                       r_prod_valid;
    logic                       r_prod_last;
    logic signed [31:0]         r_prod [3][3];
    logic                       r_w_valid;
    logic                       r_w_last;
    logic                       r_w_hit;
    logic signed [COORD_W-1:0]  r_w [3];
    logic signed [COORD_W-1:0]  n_w [3];
    logic [2:0]                 n_hit;
    logic signed [COORD_W-1:0]  r_min [3];
    logic signed [COORD_W-1:0]  r_max [3];
    logic signed [COORD_W-1:0]  n_min [3];
    logic signed [COORD_W-1:0]  n_max [3];
    logic                       r_clamp;
    logic                       r_fin_valid;
    logic                       r_fin_sat;
    logic signed [COORD_W-1:0]  r_fin_min [3];
    logic signed [COORD_W-1:0]  r_fin_max [3];
    logic                       r_out_valid;
    t_box                       r_out;
    t_box                       n_out;

    assign advance     = !(r_out_valid && i_stall);
    assign o_stall     = !advance;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW_X_RST;
            r_row[1] <= ROW_Y_RST;
            r_row[2] <= ROW_Z_RST;
            r_trans  <= '0;
            r_pad    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROW_X: r_row[0] <= i_cfg_data[47:0];
                REG_ROW_Y: r_row[1] <= i_cfg_data[47:0];
                REG_ROW_Z: r_row[2] <= i_cfg_data[47:0];
                REG_TRANS: r_trans  <= i_cfg_data[62:0];
                REG_PAD:   r_pad    <= i_cfg_data[47:0];
                default: begin
                end
            endcase
        end
    end

    // world coordinate: sum of products, round half up, add offset, clamp
    always_comb begin
        logic signed [33:0] acc;
        logic signed [21:0] rnd;
        logic signed [24:0] sum;
        for (int a = 0; a < 3; a++) begin
            acc = 34'(r_prod[a][0]) + 34'(r_prod[a][1]) + 34'(r_prod[a][2]) + 34'sd2048;
            rnd = $signed(acc[33:12]);
            sum = 25'(rnd) + 25'($signed(r_trans[OFS_W*a +: OFS_W]));
            n_hit[a] = 1'b0;
            if (sum > 25'(S24_MAX)) begin
                n_w[a]   = S24_MAX;
                n_hit[a] = 1'b1;
            end else if (sum < 25'(S24_MIN)) begin
                n_w[a]   = S24_MIN;
                n_hit[a] = 1'b1;
            end else begin
                n_w[a] = sum[COORD_W-1:0];
            end
        end
    end

    // running extremes including the current point
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_min[a] = (r_w[a] < r_min[a]) ? r_w[a] : r_min[a];
            n_max[a] = (r_w[a] > r_max[a]) ? r_w[a] : r_max[a];
        end
    end

    // padded minimum and size, clamped
    always_comb begin
        logic signed [25:0] lo;
        logic signed [26:0] size;
        logic               sat;
        logic signed [COORD_W-1:0] lo_c [3];
        logic [COORD_W-1:0]        size_c [3];
        sat = r_fin_sat;
        for (int a = 0; a < 3; a++) begin
            lo = 26'(r_fin_min[a]) - $signed({10'd0, r_pad[PAD_W*a +: PAD_W]});
            size = 27'(r_fin_max[a]) - 27'(r_fin_min[a])
                 + $signed({10'd0, r_pad[PAD_W*a +: PAD_W], 1'b0});
            if (lo > 26'(S24_MAX)) begin
                lo_c[a] = S24_MAX;
                sat = 1'b1;
            end else if (lo < 26'(S24_MIN)) begin
                lo_c[a] = S24_MIN;
                sat = 1'b1;
            end else begin
                lo_c[a] = lo[COORD_W-1:0];
            end
            if (size > $signed({3'd0, U24_MAX})) begin
                size_c[a] = U24_MAX;
                sat = 1'b1;
            end else if (size < 27'sd0) begin
                size_c[a] = '0;
                sat = 1'b1;
            end else begin
                size_c[a] = size[COORD_W-1:0];
            end
        end
        n_out.box_min_x  = lo_c[0];
        n_out.box_min_y  = lo_c[1];
        n_out.box_min_z  = lo_c[2];
        n_out.box_size_x = size_c[0];
        n_out.box_size_y = size_c[1];
        n_out.box_size_z = size_c[2];
        n_out.saturated  = sat;
    end

    // pipeline valids and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_prod_valid <= 1'b0;
            r_w_valid    <= 1'b0;
            r_fin_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_clamp      <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= S24_MAX;
                r_max[a] <= S24_MIN;
            end
        end else if (advance) begin
            r_in_valid   <= i_valid;
            r_prod_valid <= r_in_valid;
            r_w_valid    <= r_prod_valid;
            r_fin_valid  <= r_w_valid && r_w_last;
            r_out_valid  <= r_fin_valid;
            if (r_w_valid) begin
                if (r_w_last) begin
                    r_clamp <= 1'b0;
                    for (int a = 0; a < 3; a++) begin
                        r_min[a] <= S24_MAX;
                        r_max[a] <= S24_MIN;
                    end
                end else begin
                    r_clamp <= r_clamp || r_w_hit;
                    for (int a = 0; a < 3; a++) begin
                        r_min[a] <= n_min[a];
                        r_max[a] <= n_max[a];
                    end
                end
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_in        <= i_data;
            r_prod_last <= r_in.last_vertex;
            for (int a = 0; a < 3; a++) begin
                r_prod[a][0] <= $signed(r_row[a][15:0])  * r_in.vertex_x;
                r_prod[a][1] <= $signed(r_row[a][31:16]) * r_in.vertex_y;
                r_prod[a][2] <= $signed(r_row[a][47:32]) * r_in.vertex_z;
            end
            r_w_last <= r_prod_last;
            r_w_hit  <= |n_hit;
            for (int a = 0; a < 3; a++) begin
                r_w[a]       <= n_w[a];
                r_fin_min[a] <= n_min[a];
                r_fin_max[a] <= n_max[a];
            end
            r_fin_sat <= r_clamp || r_w_hit;
            r_out     <= n_out;
        end
    end

    // a snapshot always reaches the output word
    a_fin_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_fin_valid |=> r_out_valid)
        else $error("box snapshot lost");

    // the last vertex re-arms the running extremes
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_w_valid && r_w_last |=> r_min[0] == S24_MAX && r_max[2] == S24_MIN
            && !r_clamp)
        else $error("extremes not re-armed");

    // unsaturated x size never falls below twice the x padding
    a_size_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.saturated |->
            r_out.box_size_x >= {7'd0, r_pad[15:0], 1'b0})
        else $error("size below padding");

    // a frozen pipeline keeps its running state
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_min[1]) && $stable(r_max[1]))
        else $error("state moved during stall");

endmodule

// File: tb/sv/transformed_vertex_bounding_box_tb.sv
`timescale 1ns / 100ps

module transformed_vertex_bounding_box_tb;
    import tvbb_pkg::*;

    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     HOLD_CYCLES = 400;
    localparam int     CHUNK_ITEMS = 300;
    localparam int     CHUNKS      = 6;
    localparam longint S24_HI      = longint'(S24_MAX);
    localparam longint S24_LO      = longint'(S24_MIN);
    localparam longint U24_HI      = longint'(U24_MAX);

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    t_vertex            i_data;
    logic               o_valid;
    logic               i_stall;
    t_box               o_data;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;

    // Vertices waiting to be sent, boxes waiting to come back
    t_vertex pending_vertices [$];
    t_box    pending_boxes [$];

    // Shadow of the block: registers and running extremes
    logic [47:0] mat_row [3];
    logic [62:0] trans_reg;
    logic [47:0] pad_reg;
    longint      run_min [3];
    longint      run_max [3];
    bit          clamp_hit;

    int err_cnt    = 0;
    int box_cnt    = 0;
    int idle_pct   = 20;
    int send_gap   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_arm   = 1'b0;
    bit hold_used  = 1'b0;
    int cycle_cnt  = 0;

    transformed_vertex_bounding_box DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint sext_bits(input logic [63:0] v, input int w);
        logic [63:0] m;
        logic [63:0] s;
        m = (64'd1 << w) - 64'd1;
        s = 64'd1 << (w - 1);
        return longint'((v & m) ^ s) - longint'(s);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_reg();
        case ($urandom_range(0, 3))
            0: return '1;
            1: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic rearm_extremes();
        for (int a = 0; a < 3; a++) begin
            run_min[a] = S24_HI;
            run_max[a] = S24_LO;
        end
        clamp_hit = 1'b0;
    endtask

    // Map one vertex to world space, fold it into the box, emit on last
    task automatic map_and_track(input t_vertex vtx);
        longint      obj [3];
        longint      acc, wld, pad, lo, ext;
        logic [23:0] lo_f [3];
        logic [23:0] ext_f [3];
        t_box        box;
        bit          sat;
        obj[0] = longint'($signed(vtx.vertex_x));
        obj[1] = longint'($signed(vtx.vertex_y));
        obj[2] = longint'($signed(vtx.vertex_z));
        for (int a = 0; a < 3; a++) begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += sext_bits(64'(mat_row[a] >> (16 * j)), 16) * obj[j];
            // round half up in Q4.12, then translate
            wld = ((acc + 2048) >>> 12) + sext_bits(64'(trans_reg >> (21 * a)), 21);
            if (wld > S24_HI) begin
                wld = S24_HI;
                clamp_hit = 1'b1;
            end else if (wld < S24_LO) begin
                wld = S24_LO;
                clamp_hit = 1'b1;
            end
            if (wld < run_min[a]) run_min[a] = wld;
            if (wld > run_max[a]) run_max[a] = wld;
        end
        if (vtx.last_vertex) begin
            sat = clamp_hit;
            for (int a = 0; a < 3; a++) begin
                pad = longint'((pad_reg >> (16 * a)) & 48'hFFFF);
                lo  = run_min[a] - pad;
                if (lo < S24_LO) begin
                    lo  = S24_LO;
                    sat = 1'b1;
                end else if (lo > S24_HI) begin
                    lo  = S24_HI;
                    sat = 1'b1;
                end
                ext = run_max[a] - run_min[a] + 2 * pad;
                if (ext > U24_HI) begin
                    ext = U24_HI;
                    sat = 1'b1;
                end else if (ext < 0) begin
                    ext = 0;
                    sat = 1'b1;
                end
                lo_f[a]  = lo[23:0];
                ext_f[a] = ext[23:0];
            end
            box.box_min_x  = lo_f[0];
            box.box_min_y  = lo_f[1];
            box.box_min_z  = lo_f[2];
            box.box_size_x = ext_f[0];
            box.box_size_y = ext_f[1];
            box.box_size_z = ext_f[2];
            box.saturated  = sat;
            pending_boxes.insert(pending_boxes.size(), box);
            rearm_extremes();
        end
    endtask

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic cmp_field(input string name, input logic signed [63:0] got,
                             input logic signed [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("box %0d %s: got %0d, expected %0d",
                                      box_cnt, name, got, want));
    endtask

    task automatic check_box(input t_box got);
        t_box want;
        if (pending_boxes.size() == 0) begin
            report_mismatch($sformatf("box %0d arrived with none expected", box_cnt));
        end else begin
            want = pending_boxes.pop_front();
            cmp_field("box_min_x", 64'($signed(got.box_min_x)),
                      64'($signed(want.box_min_x)));
            cmp_field("box_min_y", 64'($signed(got.box_min_y)),
                      64'($signed(want.box_min_y)));
            cmp_field("box_min_z", 64'($signed(got.box_min_z)),
                      64'($signed(want.box_min_z)));
            cmp_field("box_size_x", 64'(got.box_size_x), 64'(want.box_size_x));
            cmp_field("box_size_y", 64'(got.box_size_y), 64'(want.box_size_y));
            cmp_field("box_size_z", 64'(got.box_size_z), 64'(want.box_size_z));
            cmp_field("saturated", 64'(got.saturated), 64'(want.saturated));
        end
        box_cnt++;
    endtask

    // Vertex driver: loads the next word once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                map_and_track(i_data);
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_vertices.size() != 0) begin
                    i_data  <= pending_vertices.pop_front();
                    i_valid <= 1'b1;
                    send_gap = ($urandom_range(0, 99) < idle_pct) ? gap_len() : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, fired once when armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // Box monitor with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                check_box(o_data);
            if (stall_left > 0)
                stall_left--;
            else if ($urandom_range(0, 99) < idle_pct)
                stall_left = gap_len();
            i_stall <= (stall_left > 0) || (hold_left > 0);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("transformed_vertex_bounding_box_tb: FAIL");
        $finish;
    end

    task automatic queue_vertex(input logic [15:0] x, input logic [15:0] y,
                                input logic [15:0] z, input logic last);
        t_vertex vtx;
        vtx.vertex_x    = x;
        vtx.vertex_y    = y;
        vtx.vertex_z    = z;
        vtx.last_vertex = last;
        pending_vertices.insert(pending_vertices.size(), vtx);
    endtask

    // Wait for every word out and back, then for the pipeline to settle
    task automatic drain();
        do @(negedge i_clk);
        while (pending_vertices.size() != 0 || i_valid || pending_boxes.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // Called right after a rising edge; valid stays up across back-to-back writes
    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            REG_ROW_X: mat_row[0] = data[47:0];
            REG_ROW_Y: mat_row[1] = data[47:0];
            REG_ROW_Z: mat_row[2] = data[47:0];
            REG_TRANS: trans_reg  = data[62:0];
            REG_PAD:   pad_reg    = data[47:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [63:0] rx, input logic [63:0] ry,
                             input logic [63:0] rz, input logic [63:0] tr,
                             input logic [63:0] pd, input bit spare_too);
        logic [IDX_W-1:0] spare;
        cfg_write(REG_ROW_X, rx);
        cfg_write(REG_ROW_Y, ry);
        cfg_write(REG_ROW_Z, rz);
        cfg_write(REG_TRANS, tr);
        cfg_write(REG_PAD, pd);
        // an index past the last register must be ignored
        if (spare_too || $urandom_range(0, 3) == 0) begin
            spare = IDX_W'($urandom_range(int'(REG_PAD) + 1, (1 << IDX_W) - 1));
            cfg_write(spare, {$urandom, $urandom});
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int n;
        int len;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_ROW_X;
        i_cfg_data  = '0;
        mat_row[0]  = ROW_X_RST;
        mat_row[1]  = ROW_Y_RST;
        mat_row[2]  = ROW_Z_RST;
        trans_reg   = '0;
        pad_reg     = '0;
        rearm_extremes();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset transform: single point, full-range corners, near zero
        @(negedge i_clk);
        queue_vertex(16'h0000, 16'h0000, 16'h0000, 1'b1);
        queue_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
        queue_vertex(16'h8000, 16'h7FFF, 16'h8000, 1'b1);
        queue_vertex(16'hFFFF, 16'h0001, 16'hFFFF, 1'b1);
        drain();

        // Largest coefficients, offsets at both ends, full padding
        write_all(64'hFFFF_7FFF_7FFF_7FFF, 64'h0000_8000_8000_8000,
                  64'h0000_0001_8000_7FFF,
                  {1'b1, 21'h1FFFFF, 21'h100000, 21'h0FFFFF},
                  64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        @(negedge i_clk);
        queue_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        queue_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1);
        queue_vertex(16'h7FFF, 16'h8000, 16'h0000, 1'b1);
        drain();

        // Smallest coefficients: half-unit ties and their neighbors
        write_all(64'h0000_0000_0000_0001, 64'h0000_0000_FFFF_0000,
                  64'h0000_0001_0000_0000, 64'h0, 64'h0000_0001_0000_8000, 1'b0);
        @(negedge i_clk);
        queue_vertex(16'd2048, 16'd2048, -16'sd2048, 1'b1);
        queue_vertex(-16'sd2048, -16'sd2048, 16'd2047, 1'b1);
        queue_vertex(16'd2047, -16'sd2049, -16'sd2049, 1'b0);
        queue_vertex(-16'sd2049, 16'd2047, 16'd4095, 1'b1);
        queue_vertex(16'd6144, -16'sd6144, 16'd6143, 1'b1);
        drain();

        // Random sets under random transforms
        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            write_all(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(), 1'b0);
            case (chunk)
                0: idle_pct <= 0;
                1: idle_pct <= 30;
                2: begin
                    idle_pct <= 10;
                    hold_arm <= 1'b1;
                end
                default: idle_pct <= ($urandom_range(0, 1) == 0) ? 5 : 60;
            endcase
            @(negedge i_clk);
            n = 0;
            while (n < CHUNK_ITEMS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 6);
                for (int k = 1; k <= len; k++)
                    queue_vertex(rand_coord(), rand_coord(), rand_coord(), k == len);
                n += len;
            end
            drain();
        end

        if (err_cnt == 0)
            $display("transformed_vertex_bounding_box_tb: PASS");
        else
            $display("transformed_vertex_bounding_box_tb: FAIL");
        $finish;
    end

endmodule
